/* hw/rtl/joint_angles_to_axis_vector_assert.svh */
// Assertion macros shared by the joint angle to axis vector RTL.
`ifndef JOINT_ANGLES_TO_AXIS_VECTOR_ASSERT_SVH
`define JOINT_ANGLES_TO_AXIS_VECTOR_ASSERT_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define JAAV_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must start in the cycle after the antecedent.
`define JAAV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define JAAV_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define JAAV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* hw/rtl/jaav_pkg.sv */
// Types, constants and the quarter-wave sine table for the axis vector block.
package jaav_pkg;

    localparam int ANGLE_WIDTH      = 16;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int OUT_FRAC_BITS    = 15;
    localparam int FIELD_WIDTH      = 16;

    // The table depth is a power of two, so the phase splits into quadrant and offset.
    localparam int DEPTH_LOG2  = $clog2(SINE_TABLE_DEPTH);
    localparam int PHASE_WIDTH = DEPTH_LOG2 + 2;
    localparam int INDEX_WIDTH = DEPTH_LOG2 + 1;

    localparam logic [63:0] PI_HALF_Q60 = 64'h1921FB54442D1847;
    localparam logic [63:0] ROM_Q       = PI_HALF_Q60 / SINE_TABLE_DEPTH;
    localparam logic [63:0] ROM_R       = PI_HALF_Q60 % SINE_TABLE_DEPTH;
    localparam logic [63:0] SERIES_DIV [10] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
          64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

    typedef struct packed {
        logic signed [FIELD_WIDTH-1:0] pan_angle;
        logic signed [FIELD_WIDTH-1:0] tilt_angle;
    } t_cmd;

    typedef struct packed {
        logic signed [FIELD_WIDTH-1:0] dir_x;
        logic signed [FIELD_WIDTH-1:0] dir_y;
        logic signed [FIELD_WIDTH-1:0] dir_z;
    } t_result;

    // Table addresses and signs for the sine and cosine of one angle.
    typedef struct packed {
        logic [INDEX_WIDTH-1:0] sin_idx;
        logic                   sin_neg;
        logic [INDEX_WIDTH-1:0] cos_idx;
        logic                   cos_neg;
    } t_fold;

    typedef logic [OUT_FRAC_BITS-1:0] t_sine_rom [0:SINE_TABLE_DEPTH];

    // Taylor series for sin(x) with x in Q30, evaluated at elaboration only.
    function automatic logic [63:0] series_sin_q30(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        for (int n = 1; n <= 10; n++) begin
            term = ((term * x2) >> 30) / SERIES_DIV[n-1];
            if (n[0]) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        return (sum < 0) ? 64'd0 : unsigned'(sum);
    endfunction

    function automatic t_sine_rom build_sine_rom();
        t_sine_rom   rom;
        logic [63:0] x60;
        logic [63:0] s30;
        logic [63:0] v;
        logic [63:0] maxv;
        maxv = (64'd1 << OUT_FRAC_BITS) - 64'd1;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            x60 = ROM_Q * 64'(k) + (ROM_R * 64'(k)) / SINE_TABLE_DEPTH;
            s30 = series_sin_q30(x60 >> 30);
            v   = (s30 + (64'd1 << (29 - OUT_FRAC_BITS))) >> (30 - OUT_FRAC_BITS);
            if (v > maxv) begin
                v = maxv;
            end
            rom[k] = v[OUT_FRAC_BITS-1:0];
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();

endpackage

/* hw/rtl/jaav_phase_fold.sv */
// Maps a binary angle to quarter-wave table addresses and signs for sine and cosine.
module jaav_phase_fold
    import jaav_pkg::*;
(
    input  logic signed [FIELD_WIDTH-1:0] i_angle,
    output t_fold                         o_fold
);

    logic signed [31:0]                       ext;
    logic [ANGLE_WIDTH-1:0]                   angle_mod;
    logic [ANGLE_WIDTH+PHASE_WIDTH-1:0]       scaled;
    logic [PHASE_WIDTH-1:0]                   phase;
    logic [1:0]                               quad_sin;
    logic [1:0]                               quad_cos;
    logic [INDEX_WIDTH-1:0]                   off;
    logic [INDEX_WIDTH-1:0]                   mirror;

    // The angle is taken modulo a full turn, then scaled to table phase units.
    assign ext       = 32'(i_angle);
    assign angle_mod = ext[ANGLE_WIDTH-1:0];
    assign scaled    = {angle_mod, PHASE_WIDTH'(0)};
    assign phase     = scaled[ANGLE_WIDTH+PHASE_WIDTH-1:ANGLE_WIDTH];

    assign quad_sin = phase[PHASE_WIDTH-1:PHASE_WIDTH-2];
    assign quad_cos = quad_sin + 2'd1;
    assign off      = {1'b0, phase[DEPTH_LOG2-1:0]};
    assign mirror   = INDEX_WIDTH'(SINE_TABLE_DEPTH) - off;

    // Odd quadrants read the table backward; the upper half turn is negative.
    always_comb begin
        o_fold.sin_idx = quad_sin[0] ? mirror : off;
        o_fold.sin_neg = quad_sin[1];
        o_fold.cos_idx = quad_cos[0] ? mirror : off;
        o_fold.cos_neg = quad_cos[1];
    end

endmodule

/* hw/rtl/jaav_sine_rom.sv */
// Quarter-wave sine table with a registered read port.
module jaav_sine_rom
    import jaav_pkg::*;
(
    input  logic                     i_clk,
    input  logic [INDEX_WIDTH-1:0]   i_addr,
    output logic [OUT_FRAC_BITS-1:0] o_data
);

    logic [OUT_FRAC_BITS-1:0] r_data;

    always_ff @(posedge i_clk) begin
        r_data <= SINE_ROM[i_addr];
    end

    assign o_data = r_data;

endmodule

/* hw/rtl/jaav_scale.sv */
// dir_x and dir_y as rounded products of table magnitudes, dir_z as negated tilt cosine, held in the result register.
module jaav_scale
    import jaav_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [OUT_FRAC_BITS-1:0] i_cos_pan,
    input  logic                     i_cos_pan_neg,
    input  logic [OUT_FRAC_BITS-1:0] i_sin_pan,
    input  logic                     i_sin_pan_neg,
    input  logic [OUT_FRAC_BITS-1:0] i_sin_tilt,
    input  logic                     i_sin_tilt_neg,
    input  logic [OUT_FRAC_BITS-1:0] i_cos_tilt,
    input  logic                     i_cos_tilt_neg,
    output logic                     o_valid,
    output t_result                  o_result
);

    // Rounds half away from zero, which on magnitudes is a plain half-up add.
    function automatic logic [OUT_FRAC_BITS-1:0] mul_mag(
        input logic [OUT_FRAC_BITS-1:0] a,
        input logic [OUT_FRAC_BITS-1:0] b
    );
        logic [2*OUT_FRAC_BITS-1:0] prod;
        prod = (2*OUT_FRAC_BITS)'(a) * (2*OUT_FRAC_BITS)'(b)
             + ((2*OUT_FRAC_BITS)'(1) << (OUT_FRAC_BITS - 1));
        return prod[2*OUT_FRAC_BITS-1:OUT_FRAC_BITS];
    endfunction

    function automatic logic [FIELD_WIDTH-1:0] apply_sign(
        input logic [OUT_FRAC_BITS-1:0] mag,
        input logic                     neg
    );
        logic signed [31:0] wide;
        wide = neg ? -signed'(32'(mag)) : signed'(32'(mag));
        return wide[FIELD_WIDTH-1:0];
    endfunction

    logic    r_valid;
    t_result r_result;
    t_result n_result;

    always_comb begin
        n_result.dir_x = apply_sign(mul_mag(i_cos_pan, i_sin_tilt),
                                    i_cos_pan_neg ^ i_sin_tilt_neg);
        n_result.dir_y = apply_sign(mul_mag(i_sin_pan, i_sin_tilt),
                                    i_sin_pan_neg ^ i_sin_tilt_neg);
        n_result.dir_z = apply_sign(i_cos_tilt, !i_cos_tilt_neg);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

/* hw/rtl/joint_angles_to_axis_vector.sv */
// Top level: joint angles in, insertion axis unit vector out.
//
// A command word carries pan and tilt as signed binary angles, a full turn
// being the whole angle range. It is taken at a rising edge with start high
// and busy low. busy never rises, so a word may be issued in every cycle.
//
// Each word yields one result word; o_valid is high for one cycle, o_result
// holds dir_x, dir_y and dir_z in signed Q1.15. Registered reads of four
// quarter-wave sine table copies come first, then the result register takes
// the two rounded products and signs. Throughput is one word per clock.
//
// The receiver cannot stall; a result is present for its one cycle only.
// A synchronous reset drops any words in flight, and no result follows
// them. The sine table is constant and needs no setup after reset.
`include "joint_angles_to_axis_vector_assert.svh"

module joint_angles_to_axis_vector
    import jaav_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_cmd    i_cmd,
    output logic    o_valid,
    output t_result o_result
);

    t_fold pan_fold;
    t_fold tilt_fold;

    logic [OUT_FRAC_BITS-1:0] sin_pan;
    logic [OUT_FRAC_BITS-1:0] cos_pan;
    logic [OUT_FRAC_BITS-1:0] sin_tilt;
    logic [OUT_FRAC_BITS-1:0] cos_tilt;

    logic r_lookup_valid;
    logic r_sin_pan_neg;
    logic r_cos_pan_neg;
    logic r_sin_tilt_neg;
    logic r_cos_tilt_neg;

    assign busy = 1'b0;

    jaav_phase_fold u_pan_fold (
        .i_angle (i_cmd.pan_angle),
        .o_fold  (pan_fold)
    );

    jaav_phase_fold u_tilt_fold (
        .i_angle (i_cmd.tilt_angle),
        .o_fold  (tilt_fold)
    );

    jaav_sine_rom u_rom_sin_pan (
        .i_clk  (i_clk),
        .i_addr (pan_fold.sin_idx),
        .o_data (sin_pan)
    );

    jaav_sine_rom u_rom_cos_pan (
        .i_clk  (i_clk),
        .i_addr (pan_fold.cos_idx),
        .o_data (cos_pan)
    );

    jaav_sine_rom u_rom_sin_tilt (
        .i_clk  (i_clk),
        .i_addr (tilt_fold.sin_idx),
        .o_data (sin_tilt)
    );

    jaav_sine_rom u_rom_cos_tilt (
        .i_clk  (i_clk),
        .i_addr (tilt_fold.cos_idx),
        .o_data (cos_tilt)
    );

    // Signs travel alongside the table reads.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lookup_valid <= 1'b0;
        end else begin
            r_lookup_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sin_pan_neg  <= pan_fold.sin_neg;
        r_cos_pan_neg  <= pan_fold.cos_neg;
        r_sin_tilt_neg <= tilt_fold.sin_neg;
        r_cos_tilt_neg <= tilt_fold.cos_neg;
    end

    jaav_scale u_scale (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (r_lookup_valid),
        .i_cos_pan      (cos_pan),
        .i_cos_pan_neg  (r_cos_pan_neg),
        .i_sin_pan      (sin_pan),
        .i_sin_pan_neg  (r_sin_pan_neg),
        .i_sin_tilt     (sin_tilt),
        .i_sin_tilt_neg (r_sin_tilt_neg),
        .i_cos_tilt     (cos_tilt),
        .i_cos_tilt_neg (r_cos_tilt_neg),
        .o_valid        (o_valid),
        .o_result       (o_result)
    );

    `JAAV_ASSERT_NEXT(a_word_gives_result, i_clk, i_rst_n, start && !busy, ##1 o_valid, "accepted word produced no result")
    `JAAV_ASSERT_SAME(a_result_has_word, i_clk, i_rst_n, o_valid, $past(start, 2), "result without an accepted word")
    `JAAV_ASSERT_SAME(a_zero_pan_zero_y, i_clk, i_rst_n, o_valid && ($past(i_cmd.pan_angle, 2) == '0), o_result.dir_y == '0, "zero pan gave nonzero y")

endmodule
